### sv/sbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Spectrum bar falloff package
// Shared widths, word formats and arithmetic helpers of the falloff block.
// ============================================================================
package sbf_pkg;

    localparam int BIN_W     = 8;
    localparam int MAG_W     = 16;
    localparam int LEVEL_W   = 16;
    localparam int BIN_SPACE = 1 << BIN_W;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'd32768;

    // Square root of a Q8.8 level shifted up by 8 bits: 24-bit radicand, 12-bit root.
    localparam int RAD_W            = 24;
    localparam int ROOT_W           = RAD_W / 2;
    localparam int REM_W            = 16;
    localparam int DIGITS_PER_STAGE = 3;
    localparam int SQRT_STAGES      = ROOT_W / DIGITS_PER_STAGE;

    // Division by six as a multiplication by the rounded-up reciprocal 2^16/6.
    localparam int                 RECIP_W     = 14;
    localparam logic [RECIP_W-1:0] RECIP6      = 14'd10923;
    localparam int                 RECIP_SHIFT = 16;
    localparam int                 PROD_W      = ROOT_W + RECIP_W;
    localparam int                 PEAK_STEP_W = PROD_W - RECIP_SHIFT;
    localparam int                 BAR_STEP_W  = ROOT_W - 1;

    // Pipeline registers between the queue head and the result queue.
    localparam int PIPE_REGS = SQRT_STAGES + 3;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 16;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BAR_ENABLE  = 1'b0,
        CFG_PEAK_ENABLE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic [LEVEL_W-1:0] mag;
        logic               in_range;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic               valid;
        item_t              item;
        logic [LEVEL_W-1:0] lvl_bar;
        logic [LEVEL_W-1:0] lvl_peak;
        logic               jump_bar;
        logic               jump_peak;
        sqrt_t              sq_bar;
        sqrt_t              sq_peak;
    } pipe_t;

    typedef struct packed {
        logic                  valid;
        item_t                 item;
        logic [LEVEL_W-1:0]    lvl_bar;
        logic [LEVEL_W-1:0]    lvl_peak;
        logic                  jump_bar;
        logic                  jump_peak;
        logic [BAR_STEP_W-1:0] step_bar;
        logic [PROD_W-1:0]     prod;
    } mul_t;

    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic [LEVEL_W-1:0] bar;
        logic [LEVEL_W-1:0] peak;
        logic               active;
        logic               last;
    } result_t;

    // One digit of a restoring square root: brings in two radicand bits.
    function automatic sqrt_t sqrt_digit(input sqrt_t s);
        sqrt_t             n;
        logic [REM_W-1:0]  r;
        logic [REM_W-1:0]  t;
        r      = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
        t      = {2'b00, s.root, 2'b01};
        n.rad  = {s.rad[RAD_W-3:0], 2'b00};
        if (r >= t)
        begin
            n.rem  = r - t;
            n.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            n.rem  = r;
            n.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return n;
    endfunction

    // Jump to the magnitude, or fall by the step and stop at zero.
    function automatic logic [LEVEL_W-1:0] track_level(
        input logic [LEVEL_W-1:0] lvl,
        input logic               jump,
        input logic [LEVEL_W-1:0] mag,
        input logic [LEVEL_W-1:0] step
    );
        logic [LEVEL_W-1:0] res;
        if (jump)
            res = mag;
        else if (step >= lvl)
            res = '0;
        else
            res = lvl - step;
        return res;
    endfunction

endpackage
`default_nettype wire

### sv/sbf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module sbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### sv/sbf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Generic word queue
// Register-based first-in first-out queue with a fill count.
// ============================================================================
module sbf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           wdata,
    output logic                            full,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           rdata,
    output logic                            empty,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (do_push)
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        if (do_pop)
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

### sv/sbf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Falloff front end
// Accepts input words, saturates the magnitude, checks the bin range and
// queues the classified word for the level pipeline.
// ============================================================================
module sbf_front #(
    parameter int MAX_BINS = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [sbf_pkg::BIN_W-1:0]   bin_index,
    input  wire logic [sbf_pkg::MAG_W-1:0]   magnitude,
    input  wire logic                        frame_end,
    output logic                             mid_empty,
    output sbf_pkg::item_t                   mid_item,
    input  wire logic                        mid_pop
);

    import sbf_pkg::*;

    item_t                     cls;
    logic [$bits(item_t)-1:0]  mid_raw;

    always_comb
    begin
        cls.bin      = bin_index;
        cls.mag      = (magnitude > LEVEL_MAX) ? LEVEL_MAX : magnitude;
        cls.in_range = (32'(bin_index) < MAX_BINS);
        cls.last     = frame_end;
    end

    sbf_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_raw),
        .empty (mid_empty),
        .count ()
    );

    assign mid_item = item_t'(mid_raw);

endmodule
`default_nettype wire

### sv/sbf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Falloff level pipeline
// Reads the stored levels of a bin, takes both square roots in a pipeline,
// applies the falloff, writes the levels back and emits the result word.
// ============================================================================
module sbf_back #(
    parameter int MAX_BINS = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          bar_enable,
    input  wire logic                          peak_enable,
    input  wire logic                          mid_empty,
    input  wire sbf_pkg::item_t                mid_item,
    output logic                               mid_pop,
    input  wire logic [sbf_pkg::OUT_CNT_W-1:0] out_count,
    output logic                               res_push,
    output sbf_pkg::result_t                   res_word
);

    import sbf_pkg::*;

    localparam int BINS   = (MAX_BINS < BIN_SPACE) ? MAX_BINS : BIN_SPACE;
    localparam int AW     = $clog2(BINS);
    localparam int INFL_W = $clog2(PIPE_REGS + 1);

    logic                   p0_valid_reg;
    item_t                  p0_item_reg;
    logic                   vld_rd_reg;
    logic                   valid_reg [BINS];
    pipe_t                  sq_reg  [SQRT_STAGES+1];
    pipe_t                  sq_next [SQRT_STAGES+1];
    mul_t                   m_reg, m_next;
    logic [INFL_W-1:0]      infl_reg, infl_next;
    logic                   any_reg, any_next;

    logic                   hazard, credit_ok, issue;
    logic [OUT_CNT_W:0]     used;
    logic [AW-1:0]          raddr, waddr;
    logic                   we;
    logic [2*LEVEL_W-1:0]   ram_rdata, ram_wdata;
    logic [LEVEL_W-1:0]     lvl_bar, lvl_peak;
    logic [LEVEL_W-1:0]     new_bar, new_peak, tracked;
    logic [PEAK_STEP_W-1:0] step_peak;
    logic                   hit;

    // ---------------------------------------------------------------- issue
    always_comb
    begin
        hazard = 1'b0;
        if (p0_valid_reg && p0_item_reg.in_range && p0_item_reg.bin == mid_item.bin)
            hazard = 1'b1;
        for (int k = 0; k <= SQRT_STAGES; k++)
        begin
            if (sq_reg[k].valid && sq_reg[k].item.in_range &&
                sq_reg[k].item.bin == mid_item.bin)
                hazard = 1'b1;
        end
        if (m_reg.valid && m_reg.item.in_range && m_reg.item.bin == mid_item.bin)
            hazard = 1'b1;
        hazard = hazard && mid_item.in_range;
    end

    assign used      = (OUT_CNT_W+1)'(infl_reg) + (OUT_CNT_W+1)'(out_count);
    assign credit_ok = (used < (OUT_CNT_W+1)'(OUT_DEPTH));
    assign issue     = !mid_empty && !hazard && credit_ok;
    assign mid_pop   = issue;
    assign raddr     = mid_item.bin[AW-1:0];

    always_comb
    begin
        priority case (1'b1)
            issue && !m_reg.valid: infl_next = infl_reg + 1'b1;
            !issue && m_reg.valid: infl_next = infl_reg - 1'b1;
            default:               infl_next = infl_reg;
        endcase
    end

    sbf_ram #(
        .WIDTH (2 * LEVEL_W),
        .DEPTH (BINS)
    ) u_level_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------- level select, roots
    assign lvl_bar  = vld_rd_reg ? ram_rdata[2*LEVEL_W-1:LEVEL_W] : '0;
    assign lvl_peak = vld_rd_reg ? ram_rdata[LEVEL_W-1:0] : '0;

    always_comb
    begin
        sq_next[0].valid        = p0_valid_reg;
        sq_next[0].item         = p0_item_reg;
        sq_next[0].lvl_bar      = lvl_bar;
        sq_next[0].lvl_peak     = lvl_peak;
        sq_next[0].jump_bar     = (p0_item_reg.mag >= lvl_bar);
        sq_next[0].jump_peak    = (p0_item_reg.mag >= lvl_peak);
        sq_next[0].sq_bar.rad   = {lvl_bar, 8'h00};
        sq_next[0].sq_bar.rem   = '0;
        sq_next[0].sq_bar.root  = '0;
        sq_next[0].sq_peak.rad  = {lvl_peak, 8'h00};
        sq_next[0].sq_peak.rem  = '0;
        sq_next[0].sq_peak.root = '0;
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            sq_next[k+1] = sq_reg[k];
            for (int d = 0; d < DIGITS_PER_STAGE; d++)
            begin
                sq_next[k+1].sq_bar  = sqrt_digit(sq_next[k+1].sq_bar);
                sq_next[k+1].sq_peak = sqrt_digit(sq_next[k+1].sq_peak);
            end
        end
    end

    // ------------------------------------------------------------- steps
    always_comb
    begin
        m_next.valid     = sq_reg[SQRT_STAGES].valid;
        m_next.item      = sq_reg[SQRT_STAGES].item;
        m_next.lvl_bar   = sq_reg[SQRT_STAGES].lvl_bar;
        m_next.lvl_peak  = sq_reg[SQRT_STAGES].lvl_peak;
        m_next.jump_bar  = sq_reg[SQRT_STAGES].jump_bar;
        m_next.jump_peak = sq_reg[SQRT_STAGES].jump_peak;
        m_next.step_bar  = sq_reg[SQRT_STAGES].sq_bar.root[ROOT_W-1:1];
        m_next.prod      = PROD_W'(sq_reg[SQRT_STAGES].sq_peak.root) * PROD_W'(RECIP6);
    end

    // ------------------------------------------------- update, write back
    assign step_peak = m_reg.prod[RECIP_SHIFT +: PEAK_STEP_W];

    always_comb
    begin
        new_bar  = m_reg.lvl_bar;
        new_peak = m_reg.lvl_peak;
        if (bar_enable)
            new_bar = track_level(m_reg.lvl_bar, m_reg.jump_bar, m_reg.item.mag,
                                  LEVEL_W'(m_reg.step_bar));
        if (peak_enable)
            new_peak = track_level(m_reg.lvl_peak, m_reg.jump_peak, m_reg.item.mag,
                                   LEVEL_W'(step_peak));
        priority if (peak_enable)
            tracked = new_peak;
        else if (bar_enable)
            tracked = new_bar;
        else
            tracked = '0;
        hit      = m_reg.item.in_range && (tracked != '0);
        any_next = any_reg;
        if (m_reg.valid)
            any_next = m_reg.item.last ? 1'b0 : (any_reg || hit);
    end

    assign we        = m_reg.valid && m_reg.item.in_range;
    assign waddr     = m_reg.item.bin[AW-1:0];
    assign ram_wdata = {new_bar, new_peak};

    assign res_push        = m_reg.valid;
    assign res_word.bin    = m_reg.item.bin;
    assign res_word.bar    = m_reg.item.in_range ? new_bar : '0;
    assign res_word.peak   = m_reg.item.in_range ? new_peak : '0;
    assign res_word.active = m_reg.item.last && (any_reg || hit);
    assign res_word.last   = m_reg.item.last;

    // --------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
            for (int k = 0; k <= SQRT_STAGES; k++)
            begin
                sq_reg[k] <= '0;
            end
            m_reg    <= '0;
            infl_reg <= '0;
            any_reg  <= 1'b0;
            for (int b = 0; b < BINS; b++)
            begin
                valid_reg[b] <= 1'b0;
            end
        end
        else
        begin
            p0_valid_reg <= issue;
            for (int k = 0; k <= SQRT_STAGES; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            m_reg    <= m_next;
            infl_reg <= infl_next;
            any_reg  <= any_next;
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p0_item_reg <= mid_item;
        vld_rd_reg  <= valid_reg[raddr];
    end

endmodule
`default_nettype wire

### sv/spectrum_bar_falloff.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Spectrum bar falloff
// Per-bin bar and peak-marker levels with square-root falloff.
// ============================================================================
// Each input word carries one spectrum bin and its magnitude; each produces
// exactly one result word with the bin's updated bar and peak levels, in
// input order. The stored levels pass through a read, square-root and
// write-back loop; a word whose bin is still in that loop waits at the head
// of the internal four-word queue until the earlier write has landed. Apart
// from such waits, a full input queue and a lack of room in the result queue,
// the block takes one word per clock. Results wait in a sixteen-word queue,
// and new words keep entering while earlier results sit unread; the pipeline
// only issues words that are sure of a place in that queue. The levels start
// at zero after reset with no clearing pass: each bin carries a written flag,
// and an unwritten bin reads as zero. bar_enable and peak_enable must be
// written through the configuration port only while the block is idle; the
// block itself does not enforce this. Only bit 0 of the write data counts.
// ============================================================================
module spectrum_bar_falloff #(
    parameter int MAX_BINS = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input queue side
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [sbf_pkg::BIN_W-1:0]       bin_index,
    input  wire logic [sbf_pkg::MAG_W-1:0]       magnitude,
    input  wire logic                            frame_end,
    // Result queue side
    input  wire logic                            pop,
    output logic                                 empty,
    output logic      [sbf_pkg::BIN_W-1:0]       out_bin,
    output logic      [sbf_pkg::LEVEL_W-1:0]     bar_level,
    output logic      [sbf_pkg::LEVEL_W-1:0]     peak_level,
    output logic                                 frame_active,
    output logic                                 out_last,
    // Configuration write port
    input  wire logic                            cfg_write,
    input  wire logic [sbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sbf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import sbf_pkg::*;

    logic                       bar_enable_reg, bar_enable_next;
    logic                       peak_enable_reg, peak_enable_next;
    logic                       mid_empty, mid_pop;
    item_t                      mid_item;
    logic                       res_push;
    result_t                    res_word;
    logic [OUT_CNT_W-1:0]       out_count;
    logic [$bits(result_t)-1:0] out_raw;
    result_t                    head;

    // Configuration registers: both trackers are on after reset.
    always_comb
    begin
        bar_enable_next  = bar_enable_reg;
        peak_enable_next = peak_enable_reg;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BAR_ENABLE:  bar_enable_next  = cfg_data[0];
                CFG_PEAK_ENABLE: peak_enable_next = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_enable_reg  <= 1'b1;
            peak_enable_reg <= 1'b1;
        end
        else
        begin
            bar_enable_reg  <= bar_enable_next;
            peak_enable_reg <= peak_enable_next;
        end
    end

    // Front end: saturation, range check and the queue to the pipeline.
    sbf_front #(
        .MAX_BINS (MAX_BINS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .bin_index (bin_index),
        .magnitude (magnitude),
        .frame_end (frame_end),
        .mid_empty (mid_empty),
        .mid_item  (mid_item),
        .mid_pop   (mid_pop)
    );

    // Back end: level read, square roots, falloff and write back.
    sbf_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .bar_enable  (bar_enable_reg),
        .peak_enable (peak_enable_reg),
        .mid_empty   (mid_empty),
        .mid_item    (mid_item),
        .mid_pop     (mid_pop),
        .out_count   (out_count),
        .res_push    (res_push),
        .res_word    (res_word)
    );

    // Result queue. The back end never pushes into a full queue, because it
    // counts its words in flight against the free places.
    sbf_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_word),
        .full  (),
        .pop   (pop),
        .rdata (out_raw),
        .empty (empty),
        .count (out_count)
    );

    assign head         = result_t'(out_raw);
    assign out_bin      = head.bin;
    assign bar_level    = head.bar;
    assign peak_level   = head.peak;
    assign frame_active = head.active;
    assign out_last     = head.last;

endmodule
`default_nettype wire

### sv/sbf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Spectrum bar falloff checker
// Port-level assertions on the result side of the falloff block.
// ============================================================================
module sbf_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        push,
    input wire logic                        full,
    input wire logic                        pop,
    input wire logic                        empty,
    input wire logic [sbf_pkg::BIN_W-1:0]   out_bin,
    input wire logic [sbf_pkg::LEVEL_W-1:0] bar_level,
    input wire logic [sbf_pkg::LEVEL_W-1:0] peak_level,
    input wire logic                        frame_active,
    input wire logic                        out_last
);

    import sbf_pkg::*;

    localparam int PEND_W = 6;

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              in_acc, out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    // Words taken in and not yet read out.
    always_comb
    begin
        unique case ({in_acc, out_acc})
            2'b10:   pend_next = pend_reg + 1'b1;
            2'b01:   pend_next = pend_reg - 1'b1;
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (pend_reg != '0))
        else $error("result word read with no input word outstanding");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_bin) && $stable(bar_level) &&
                              $stable(peak_level) && $stable(out_last)))
        else $error("waiting result word changed before it was read");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (bar_level <= LEVEL_MAX && peak_level <= LEVEL_MAX))
        else $error("level above full scale");

    a_active_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_active) |-> out_last)
        else $error("frame activity flagged on a word that does not end a frame");

endmodule

bind spectrum_bar_falloff sbf_checker u_sbf_checker (.*);
`default_nettype wire
